// ----- hdl/prg_pkg.sv -----
// ----------------------------------------------------------------------------
// Pinhole ray generator package
// Shared widths, register codes and sideband types of the ray generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package prg_pkg;

  // Packed configuration fields: three signed 20-bit fields, x in the low bits.
  localparam int unsigned FIELD_W    = 20;
  localparam int unsigned REG_W      = 3 * FIELD_W;
  localparam int unsigned LANES      = 3;
  localparam int unsigned LANE_X     = 0;
  localparam int unsigned LANE_Y     = 1;
  localparam int unsigned LANE_Z     = 2;

  // Step vectors carry 18 fractional bits; positions are scaled up to match.
  localparam int unsigned STEP_FRAC  = 18;

  // Configuration port.
  localparam int unsigned APB_DW       = 64;
  localparam int unsigned APB_AW       = 5;
  localparam int unsigned REG_ADDR_LSB = 3;
  localparam int unsigned REG_IDX_W    = APB_AW - REG_ADDR_LSB;

  localparam logic [REG_IDX_W-1:0] REG_ORIGIN = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CORNER = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEP_U = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEP_V = 2'd3;

  // Datapath widths.
  localparam int unsigned PROD_W   = 41;  // unsigned 20 bit times signed 20 bit
  localparam int unsigned D_W      = 42;  // unnormalized direction, signed
  localparam int unsigned MAG_W    = 41;  // its magnitude
  localparam int unsigned POS_W    = 6;   // leading one position in a magnitude
  localparam int unsigned NORM_W   = 30;  // normalized magnitude
  localparam int unsigned NORM_MSB = NORM_W - 1;
  localparam int unsigned SHAMT_W  = 5;   // normalizing shift amount
  localparam int unsigned SQ1_W    = 2 * NORM_W;
  localparam int unsigned SUMSQ_W  = SQ1_W + 2;
  localparam int unsigned ROOT_W   = SUMSQ_W / 2;
  localparam int unsigned REM_W    = ROOT_W + 4;
  localparam int unsigned DIR_FRAC = 15;
  localparam int unsigned NUM_W    = NORM_W + DIR_FRAC + 1;
  localparam int unsigned QUO_W    = NUM_W - ROOT_W + 1;
  localparam int unsigned DIR_W    = 16;

  localparam logic [QUO_W-1:0] POS_MAX     = 16'h7FFF;
  localparam logic [QUO_W-1:0] NEG_MAG_MAX = 16'h8000;

  typedef logic [NORM_W-1:0] nmag_t;
  typedef logic [NUM_W-1:0]  num_t;

  // Sign of each lane and the zero-length flag.
  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             zero;
  } sgn_t;

  // Data that travels alongside the square root.
  typedef struct packed {
    nmag_t [LANES-1:0] nmag;
    sgn_t              sg;
  } root_side_t;

endpackage

`default_nettype wire

// ----- hdl/prg_isqrt.sv -----
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, restoring method, with a sideband carried along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prg_isqrt (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 en,
  input  wire                                 in_valid,
  input  wire  [prg_pkg::SUMSQ_W-1:0]         radicand,
  input  prg_pkg::root_side_t                 in_side,
  output logic                                out_valid,
  output logic [prg_pkg::ROOT_W-1:0]          root,
  output prg_pkg::root_side_t                 out_side
);

  localparam int unsigned NS = prg_pkg::ROOT_W;

  logic                              vld  [NS];
  logic [prg_pkg::SUMSQ_W-1:0]       rad  [NS];
  logic [prg_pkg::REM_W-1:0]         rem  [NS];
  logic [prg_pkg::ROOT_W-1:0]        qt   [NS];
  prg_pkg::root_side_t               side [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int unsigned Pair = NS - 1 - s;

    logic                          pv;
    logic [prg_pkg::SUMSQ_W-1:0]   prad;
    logic [prg_pkg::REM_W-1:0]     prem;
    logic [prg_pkg::ROOT_W-1:0]    pq;
    prg_pkg::root_side_t           pside;
    logic [prg_pkg::REM_W-1:0]     rsh;
    logic [prg_pkg::REM_W-1:0]     trial;
    logic                          fit;

    if (s == 0) begin : g_first
      assign pv    = in_valid;
      assign prad  = radicand;
      assign prem  = '0;
      assign pq    = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld[s-1];
      assign prad  = rad[s-1];
      assign prem  = rem[s-1];
      assign pq    = qt[s-1];
      assign pside = side[s-1];
    end

    // Bring down the next bit pair and try to subtract 4q+1.
    assign rsh   = {prem[prg_pkg::REM_W-3:0], prad[2*Pair+1 -: 2]};
    assign trial = {{(prg_pkg::REM_W - prg_pkg::ROOT_W - 2){1'b0}}, pq, 2'b01};
    assign fit   = (rsh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[s]  <= prad;
        rem[s]  <= fit ? (rsh - trial) : rsh;
        qt[s]   <= {pq[prg_pkg::ROOT_W-2:0], fit};
        side[s] <= pside;
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign root      = qt[NS-1];
  assign out_side  = side[NS-1];

endmodule

`default_nettype wire

// ----- hdl/prg_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined three-lane divider
// Divides three numerators by one shared divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module prg_div (
  input  wire                                              clk,
  input  wire                                              rst,
  input  wire                                              en,
  input  wire                                              in_valid,
  input  prg_pkg::num_t [prg_pkg::LANES-1:0]               num,
  input  wire  [prg_pkg::ROOT_W-1:0]                       divisor,
  input  prg_pkg::sgn_t                                    in_sg,
  output logic                                             out_valid,
  output logic [prg_pkg::LANES-1:0][prg_pkg::QUO_W-1:0]    quo,
  output prg_pkg::sgn_t                                    out_sg
);

  localparam int unsigned NS = prg_pkg::QUO_W;

  logic                                              vld [NS];
  prg_pkg::num_t [prg_pkg::LANES-1:0]                rem [NS];
  logic [prg_pkg::ROOT_W-1:0]                        dvs [NS];
  logic [prg_pkg::LANES-1:0][prg_pkg::QUO_W-1:0]     qt  [NS];
  prg_pkg::sgn_t                                     sg  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int unsigned Bit = NS - 1 - s;

    logic                                              pv;
    prg_pkg::num_t [prg_pkg::LANES-1:0]                prem;
    logic [prg_pkg::ROOT_W-1:0]                        pdvs;
    logic [prg_pkg::LANES-1:0][prg_pkg::QUO_W-1:0]     pq;
    prg_pkg::sgn_t                                     psg;
    prg_pkg::num_t                                     shifted;
    prg_pkg::num_t [prg_pkg::LANES-1:0]                nrem;
    logic [prg_pkg::LANES-1:0][prg_pkg::QUO_W-1:0]     nq;

    if (s == 0) begin : g_first
      assign pv   = in_valid;
      assign prem = num;
      assign pdvs = divisor;
      assign pq   = '0;
      assign psg  = in_sg;
    end else begin : g_next
      assign pv   = vld[s-1];
      assign prem = rem[s-1];
      assign pdvs = dvs[s-1];
      assign pq   = qt[s-1];
      assign psg  = sg[s-1];
    end

    assign shifted = prg_pkg::NUM_W'(pdvs) << Bit;

    always_comb begin
      for (int l = 0; l < prg_pkg::LANES; l++) begin
        if (prem[l] >= shifted) begin
          nrem[l] = prem[l] - shifted;
          nq[l]   = {pq[l][prg_pkg::QUO_W-2:0], 1'b1};
        end else begin
          nrem[l] = prem[l];
          nq[l]   = {pq[l][prg_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= nrem;
        dvs[s] <= pdvs;
        qt[s]  <= nq;
        sg[s]  <= psg;
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign quo       = qt[NS-1];
  assign out_sg    = sg[NS-1];

endmodule

`default_nettype wire

// ----- hdl/pinhole_ray_generator_top.sv -----
// ----------------------------------------------------------------------------
// Pinhole ray generator
// Throughput: one request per cycle while in_stall is low; every stage is one
// register deep and all stages move on one shared enable.
// Reset (rst, synchronous): clears all valid bits and the four registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Datapath, one register per stage:
//   S0      sample capture
//   S1      u*step_u and v*step_v for all three axes (six 21x20 multipliers)
//   S2      d = (corner - origin) * 2^18 + products, exact at 18 fraction bits
//   S3      sign and magnitude of d
//   S4      leading one of the OR of the magnitudes gives a common shift
//   S5      magnitudes shifted so the largest has its top bit at bit 29
//   S6      squares, S7 their sum
//   31 square root stages, one root bit each
//   S8      numerators mag * 2^15 + L/2
//   16 divider stages, one quotient bit each, all three axes in parallel
//   S9      sign, saturation and the zero-length case
//   output register with a one-entry skid buffer
// All stages advance together while the skid buffer is empty. When the output
// side stalls, the item leaving the pipe is parked in the skid buffer and the
// pipe holds on the next cycle, so in_stall comes straight from a register.
module pinhole_ray_generator_top (
  input  wire                                clk,
  input  wire                                rst,
  // Sample request channel.
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [prg_pkg::FIELD_W-1:0]        sample_u,
  input  wire  [prg_pkg::FIELD_W-1:0]        sample_v,
  // Ray channel.
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [prg_pkg::DIR_W-1:0]   dir_x,
  output logic signed [prg_pkg::DIR_W-1:0]   dir_y,
  output logic signed [prg_pkg::DIR_W-1:0]   dir_z,
  output logic signed [prg_pkg::FIELD_W-1:0] org_x,
  output logic signed [prg_pkg::FIELD_W-1:0] org_y,
  output logic signed [prg_pkg::FIELD_W-1:0] org_z,
  // Configuration port.
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [prg_pkg::APB_AW-1:0]         paddr,
  input  wire  [prg_pkg::APB_DW-1:0]         pwdata,
  output logic [prg_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  typedef logic signed [prg_pkg::PROD_W-1:0] prod_t;
  typedef logic signed [prg_pkg::D_W-1:0]    dvec_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [prg_pkg::REG_W-1:0] origin_packed;
  logic [prg_pkg::REG_W-1:0] corner_packed;
  logic [prg_pkg::REG_W-1:0] step_u_packed;
  logic [prg_pkg::REG_W-1:0] step_v_packed;
  logic [prg_pkg::REG_IDX_W-1:0] reg_idx;
  logic cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[prg_pkg::APB_AW-1:prg_pkg::REG_ADDR_LSB];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_packed <= '0;
      corner_packed <= '0;
      step_u_packed <= '0;
      step_v_packed <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        prg_pkg::REG_ORIGIN: origin_packed <= pwdata[prg_pkg::REG_W-1:0];
        prg_pkg::REG_CORNER: corner_packed <= pwdata[prg_pkg::REG_W-1:0];
        prg_pkg::REG_STEP_U: step_u_packed <= pwdata[prg_pkg::REG_W-1:0];
        prg_pkg::REG_STEP_V: step_v_packed <= pwdata[prg_pkg::REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      prg_pkg::REG_ORIGIN: prdata = prg_pkg::APB_DW'(origin_packed);
      prg_pkg::REG_CORNER: prdata = prg_pkg::APB_DW'(corner_packed);
      prg_pkg::REG_STEP_U: prdata = prg_pkg::APB_DW'(step_u_packed);
      prg_pkg::REG_STEP_V: prdata = prg_pkg::APB_DW'(step_v_packed);
      default:             prdata = '0;
    endcase
  end

  // The user must change the registers only while the block is idle; the block does
  // not enforce this, yet presents the origin fields on the ray channel directly.
  assign org_x = $signed(origin_packed[prg_pkg::LANE_X*prg_pkg::FIELD_W +: prg_pkg::FIELD_W]);
  assign org_y = $signed(origin_packed[prg_pkg::LANE_Y*prg_pkg::FIELD_W +: prg_pkg::FIELD_W]);
  assign org_z = $signed(origin_packed[prg_pkg::LANE_Z*prg_pkg::FIELD_W +: prg_pkg::FIELD_W]);

  function automatic logic signed [prg_pkg::FIELD_W-1:0] fld(
    input logic [prg_pkg::REG_W-1:0] r,
    input int unsigned                k
  );
    return $signed(r[k*prg_pkg::FIELD_W +: prg_pkg::FIELD_W]);
  endfunction

  // --------------------------------------------------------------------------
  // Pipeline enable and stage registers
  // --------------------------------------------------------------------------
  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  logic s0_valid, s1_valid, s2_valid, s3_valid, s4_valid;
  logic s5_valid, s6_valid, s7_valid, s8_valid, fin_valid;

  logic [prg_pkg::FIELD_W-1:0] s0_u, s0_v;
  prod_t s1_pu [prg_pkg::LANES];
  prod_t s1_pv [prg_pkg::LANES];
  dvec_t s2_d  [prg_pkg::LANES];

  logic [prg_pkg::LANES-1:0][prg_pkg::MAG_W-1:0] s3_mag, s4_mag, s3_mag_next;
  logic [prg_pkg::LANES-1:0]                     s3_neg, s4_neg, s3_neg_next;
  logic                                          s4_zero, s4_right;
  logic [prg_pkg::SHAMT_W-1:0]                   s4_amt;

  prg_pkg::nmag_t [prg_pkg::LANES-1:0] s5_nmag, s6_nmag, s5_nmag_next;
  prg_pkg::sgn_t                       s5_sg, s6_sg;
  logic [prg_pkg::LANES-1:0][prg_pkg::SQ1_W-1:0] s6_sq;
  logic [prg_pkg::SUMSQ_W-1:0]         s7_sum;
  prg_pkg::root_side_t                 s7_side;

  logic                                rt_valid;
  logic [prg_pkg::ROOT_W-1:0]          rt_root;
  prg_pkg::root_side_t                 rt_side;

  prg_pkg::num_t [prg_pkg::LANES-1:0]  s8_num;
  logic [prg_pkg::ROOT_W-1:0]          s8_root;
  prg_pkg::sgn_t                       s8_sg;

  logic                                              dv_valid;
  logic [prg_pkg::LANES-1:0][prg_pkg::QUO_W-1:0]     dv_quo;
  prg_pkg::sgn_t                                     dv_sg;

  logic [prg_pkg::LANES-1:0][prg_pkg::DIR_W-1:0] fin_dir, fin_dir_next;
  logic [prg_pkg::LANES-1:0][prg_pkg::DIR_W-1:0] out_dir, skid_dir;

  // Combinational parts of S2 through S5.
  dvec_t s2_d_next [prg_pkg::LANES];
  logic [prg_pkg::MAG_W-1:0]   orm;
  logic [prg_pkg::POS_W-1:0]   pos;
  logic [prg_pkg::POS_W-1:0]   amt_wide;

  always_comb begin
    logic signed [prg_pkg::FIELD_W-1:0] cfld;
    logic signed [prg_pkg::FIELD_W-1:0] ofld;
    logic signed [prg_pkg::FIELD_W:0]   base;
    for (int l = 0; l < prg_pkg::LANES; l++) begin
      cfld = fld(corner_packed, l);
      ofld = fld(origin_packed, l);
      base = $signed({cfld[prg_pkg::FIELD_W-1], cfld}) - $signed({ofld[prg_pkg::FIELD_W-1], ofld});
      s2_d_next[l] = (prg_pkg::D_W'(base) <<< prg_pkg::STEP_FRAC)
                   + prg_pkg::D_W'(s1_pu[l]) + prg_pkg::D_W'(s1_pv[l]);
    end
  end

  always_comb begin
    dvec_t negd;
    for (int l = 0; l < prg_pkg::LANES; l++) begin
      negd           = -s2_d[l];
      s3_neg_next[l] = s2_d[l][prg_pkg::D_W-1];
      s3_mag_next[l] = s3_neg_next[l] ? negd[prg_pkg::MAG_W-1:0] : s2_d[l][prg_pkg::MAG_W-1:0];
    end
  end

  // The largest magnitude and the OR of all three share their leading one.
  assign orm = s3_mag[0] | s3_mag[1] | s3_mag[2];

  always_comb begin
    pos = '0;
    for (int i = 0; i < prg_pkg::MAG_W; i++) begin
      if (orm[i]) begin
        pos = prg_pkg::POS_W'(i);
      end
    end
  end

  assign amt_wide = (pos >= prg_pkg::POS_W'(prg_pkg::NORM_MSB))
                  ? pos - prg_pkg::POS_W'(prg_pkg::NORM_MSB)
                  : prg_pkg::POS_W'(prg_pkg::NORM_MSB) - pos;

  // Right shifts truncate each magnitude; left shifts never lose bits.
  always_comb begin
    logic [prg_pkg::MAG_W-1:0] sh;
    for (int l = 0; l < prg_pkg::LANES; l++) begin
      sh = s4_right ? (s4_mag[l] >> s4_amt) : (s4_mag[l] << s4_amt);
      s5_nmag_next[l] = sh[prg_pkg::NORM_W-1:0];
    end
  end

  // Final stage: sign, saturation and the zero-length direction.
  always_comb begin
    logic [prg_pkg::QUO_W-1:0] q;
    logic [prg_pkg::QUO_W-1:0] mq;
    for (int l = 0; l < prg_pkg::LANES; l++) begin
      q  = dv_quo[l];
      mq = (q > prg_pkg::NEG_MAG_MAX) ? prg_pkg::NEG_MAG_MAX : q;
      if (dv_sg.zero) begin
        fin_dir_next[l] = '0;
      end else if (dv_sg.neg[l]) begin
        fin_dir_next[l] = ~mq + 1'b1;
      end else begin
        fin_dir_next[l] = (q > prg_pkg::POS_MAX) ? prg_pkg::POS_MAX : q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      s8_valid  <= 1'b0;
      fin_valid <= 1'b0;
    end else if (en) begin
      s0_valid  <= in_valid;
      s1_valid  <= s0_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      s6_valid  <= s5_valid;
      s7_valid  <= s6_valid;
      s8_valid  <= rt_valid;
      fin_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_u <= sample_u;
      s0_v <= sample_v;
      for (int l = 0; l < prg_pkg::LANES; l++) begin
        s1_pu[l] <= $signed({1'b0, s0_u}) * fld(step_u_packed, l);
        s1_pv[l] <= $signed({1'b0, s0_v}) * fld(step_v_packed, l);
        s2_d[l]  <= s2_d_next[l];
      end
      s3_mag   <= s3_mag_next;
      s3_neg   <= s3_neg_next;
      s4_mag   <= s3_mag;
      s4_neg   <= s3_neg;
      s4_zero  <= (orm == '0);
      s4_right <= (pos >= prg_pkg::POS_W'(prg_pkg::NORM_MSB));
      s4_amt   <= amt_wide[prg_pkg::SHAMT_W-1:0];
      s5_nmag  <= s5_nmag_next;
      s5_sg    <= '{neg: s4_neg, zero: s4_zero};
      for (int l = 0; l < prg_pkg::LANES; l++) begin
        s6_sq[l] <= prg_pkg::SQ1_W'(s5_nmag[l]) * prg_pkg::SQ1_W'(s5_nmag[l]);
      end
      s6_nmag  <= s5_nmag;
      s6_sg    <= s5_sg;
      s7_sum   <= prg_pkg::SUMSQ_W'(s6_sq[0]) + prg_pkg::SUMSQ_W'(s6_sq[1])
                + prg_pkg::SUMSQ_W'(s6_sq[2]);
      s7_side  <= '{nmag: s6_nmag, sg: s6_sg};
      for (int l = 0; l < prg_pkg::LANES; l++) begin
        // Round half up: add half the length before dividing by it.
        s8_num[l] <= prg_pkg::NUM_W'({rt_side.nmag[l], {prg_pkg::DIR_FRAC{1'b0}}})
                   + prg_pkg::NUM_W'(rt_root >> 1);
      end
      s8_root  <= rt_root;
      s8_sg    <= rt_side.sg;
      fin_dir  <= fin_dir_next;
    end
  end

  // --------------------------------------------------------------------------
  // Length and division units
  // --------------------------------------------------------------------------
  prg_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s7_valid),
    .radicand  (s7_sum),
    .in_side   (s7_side),
    .out_valid (rt_valid),
    .root      (rt_root),
    .out_side  (rt_side)
  );

  prg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s8_valid),
    .num       (s8_num),
    .divisor   (s8_root),
    .in_sg     (s8_sg),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .out_sg    (dv_sg)
  );

  // --------------------------------------------------------------------------
  // Output register and skid buffer
  // --------------------------------------------------------------------------
  // While the skid buffer is empty, the item leaving the pipe goes to the
  // output register if that is free or being taken, and otherwise into the
  // skid buffer. A full skid buffer refills the output register when the
  // current ray is taken.
  logic out_take;

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || !out_stall) begin
      out_valid <= fin_valid;
    end else if (fin_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_dir <= skid_dir;
      end
    end else if (!out_valid || !out_stall) begin
      out_dir <= fin_dir;
    end else begin
      skid_dir <= fin_dir;
    end
  end

  assign dir_x = $signed(out_dir[prg_pkg::LANE_X]);
  assign dir_y = $signed(out_dir[prg_pkg::LANE_Y]);
  assign dir_z = $signed(out_dir[prg_pkg::LANE_Z]);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // The skid buffer only holds a ray while the output register holds one.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid buffer full while output register empty");

  // The skid buffer fills only after the output side stalled a waiting ray.
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid buffer filled without an output stall");

  // After normalization the largest magnitude has its top bit at bit 29.
  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    (s5_valid && !s5_sg.zero) |->
      (s5_nmag[0][prg_pkg::NORM_MSB] || s5_nmag[1][prg_pkg::NORM_MSB] ||
       s5_nmag[2][prg_pkg::NORM_MSB]))
    else $error("normalized magnitudes out of range");

  // A nonzero direction gives a length of at least 2^29.
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    (rt_valid && !rt_side.sg.zero) |->
      (rt_root[prg_pkg::ROOT_W-1:prg_pkg::ROOT_W-2] != 2'b00))
    else $error("vector length below normalized range");
`endif

endmodule

`default_nettype wire
